/* design/fstc_pkg.sv */
// Package: sizes and request codes for the two-set FIFO tag cache.
`default_nettype none

package fstc_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int KEY_BITS    = 64;

    localparam int ADDR_W  = $clog2(MAX_ENTRIES);
    localparam int FILL_W  = $clog2(MAX_ENTRIES + 1);
    localparam int SUM_W   = FILL_W + 1;
    localparam int CAP_W   = 7;
    localparam int COUNT_W = 7;
    localparam int TOTAL_W = 8;
    localparam int MODE_W  = 2;
    localparam int TIP_W   = 64;

    localparam logic [MODE_W-1:0] MODE_ADD     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PROMOTE = 2'd2;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

endpackage

`default_nettype wire

/* design/fstc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module fstc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* design/two_set_fifo_tag_cache_unit.sv */
// Two-set FIFO tag cache: pending and confirmed key sets in two RAMs, scanned and compacted.
// Add/remove scan the pending set; a promote that hits in it then scans the confirmed set
// too; mode three goes straight to the result. Each scan reads one RAM entry per cycle, so
// the time per request is set by the fill of the sets; a stalled result also holds the
// next.
// One request is in work at a time; a new one is taken while the last result waits.
// Reset clears both fill counts and sets set_capacity to 64; RAM contents are not cleared.
`default_nettype none

module two_set_fifo_tag_cache_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [fstc_pkg::CAP_W-1:0]    set_capacity,
    input  wire logic                          item_valid,
    output logic                               item_stall,
    input  wire logic [fstc_pkg::MODE_W-1:0]   mode,
    input  wire logic [fstc_pkg::TIP_W-1:0]    tip_key,
    output logic                               result_valid,
    input  wire logic                          result_stall,
    output logic      [fstc_pkg::COUNT_W-1:0]  pending_count,
    output logic      [fstc_pkg::COUNT_W-1:0]  confirmed_count,
    output logic      [fstc_pkg::TOTAL_W-1:0]  total_count,
    output logic                               promoted
);

    import fstc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PSCAN,
        ST_CSCAN,
        ST_FINISH
    } state_t;

    state_t                state_reg,     state_next;
    logic [CAP_W-1:0]      cap_reg,       cap_next;
    logic [FILL_W-1:0]     pfill_reg,     pfill_next;
    logic [FILL_W-1:0]     cfill_reg,     cfill_next;
    logic [KEY_BITS-1:0]   key_reg,       key_next;
    logic [MODE_W-1:0]     mode_reg,      mode_next;
    logic [FILL_W-1:0]     rd_idx_reg,    rd_idx_next;
    logic [FILL_W-1:0]     wr_ptr_reg,    wr_ptr_next;
    logic                  cmp_valid_reg, cmp_valid_next;
    logic                  cmp_first_reg, cmp_first_next;
    logic                  found_reg,     found_next;
    logic                  evict_reg,     evict_next;
    logic                  drop_reg,      drop_next;
    logic                  append_reg,    append_next;
    logic                  moved_reg,     moved_next;
    logic                  out_valid_reg, out_valid_next;
    logic [COUNT_W-1:0]    out_pcnt_reg,  out_pcnt_next;
    logic [COUNT_W-1:0]    out_ccnt_reg,  out_ccnt_next;
    logic [TOTAL_W-1:0]    out_total_reg, out_total_next;
    logic                  out_moved_reg, out_moved_next;

    logic [FILL_W-1:0]     eff_cap;
    logic                  conf_sel;
    logic [FILL_W-1:0]     scan_fill;
    logic [KEY_BITS-1:0]   rdata_sel;
    logic [KEY_BITS-1:0]   p_rdata;
    logic [KEY_BITS-1:0]   c_rdata;
    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    logic [KEY_BITS-1:0]   mem_wdata;
    logic [ADDR_W-1:0]     mem_raddr;
    logic                  kill;
    logic                  hit;
    logic                  skip;
    logic [FILL_W-1:0]     new_fill;
    logic [SUM_W-1:0]      fill_sum;

    fstc_ram #(
        .WIDTH(KEY_BITS),
        .DEPTH(MAX_ENTRIES)
    ) u_pending_ram (
        .clk  (clk),
        .we   (mem_we && !conf_sel),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .raddr(mem_raddr),
        .rdata(p_rdata)
    );

    fstc_ram #(
        .WIDTH(KEY_BITS),
        .DEPTH(MAX_ENTRIES)
    ) u_confirmed_ram (
        .clk  (clk),
        .we   (mem_we && conf_sel),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .raddr(mem_raddr),
        .rdata(c_rdata)
    );

    always_comb
    begin
        if (cap_reg == '0)
        begin
            eff_cap = FILL_W'(1);
        end
        else if (int'(cap_reg) > MAX_ENTRIES)
        begin
            eff_cap = FILL_W'(MAX_ENTRIES);
        end
        else
        begin
            eff_cap = FILL_W'(cap_reg);
        end
    end

    assign conf_sel  = (state_reg == ST_CSCAN);
    assign scan_fill = conf_sel ? cfill_reg : pfill_reg;
    assign rdata_sel = conf_sel ? c_rdata : p_rdata;
    assign mem_raddr = rd_idx_reg[ADDR_W-1:0];
    assign fill_sum  = SUM_W'(pfill_reg) + SUM_W'(cfill_reg);

    always_comb
    begin
        state_next     = state_reg;
        cap_next       = cap_reg;
        pfill_next     = pfill_reg;
        cfill_next     = cfill_reg;
        key_next       = key_reg;
        mode_next      = mode_reg;
        rd_idx_next    = rd_idx_reg;
        wr_ptr_next    = wr_ptr_reg;
        cmp_valid_next = cmp_valid_reg;
        cmp_first_next = cmp_first_reg;
        found_next     = found_reg;
        evict_next     = evict_reg;
        drop_next      = drop_reg;
        append_next    = append_reg;
        moved_next     = moved_reg;
        out_valid_next = out_valid_reg;
        out_pcnt_next  = out_pcnt_reg;
        out_ccnt_next  = out_ccnt_reg;
        out_total_next = out_total_reg;
        out_moved_next = out_moved_reg;
        mem_we         = 1'b0;
        mem_waddr      = wr_ptr_reg[ADDR_W-1:0];
        mem_wdata      = rdata_sel;
        kill           = 1'b0;
        hit            = 1'b0;
        skip           = 1'b0;
        new_fill       = wr_ptr_reg;

        if (cfg_valid)
        begin
            cap_next = set_capacity;
        end

        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    key_next       = tip_key[KEY_BITS-1:0];
                    mode_next      = mode;
                    rd_idx_next    = '0;
                    wr_ptr_next    = '0;
                    cmp_valid_next = 1'b0;
                    found_next     = 1'b0;
                    moved_next     = 1'b0;
                    evict_next     = 1'b0;
                    drop_next      = 1'b0;
                    append_next    = 1'b0;
                    unique case (mode) inside
                        MODE_ADD:
                        begin
                            evict_next  = (pfill_reg >= eff_cap) && (pfill_reg != '0);
                            append_next = 1'b1;
                            state_next  = ST_PSCAN;
                        end
                        MODE_REMOVE, MODE_PROMOTE:
                        begin
                            drop_next  = 1'b1;
                            state_next = ST_PSCAN;
                        end
                        default:
                        begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end

            ST_PSCAN, ST_CSCAN:
            begin
                if (rd_idx_reg < scan_fill)
                begin
                    rd_idx_next    = rd_idx_reg + FILL_W'(1);
                    cmp_valid_next = 1'b1;
                    cmp_first_next = (rd_idx_reg == '0);
                end
                else
                begin
                    cmp_valid_next = 1'b0;
                end

                if (cmp_valid_reg)
                begin
                    kill = evict_reg && cmp_first_reg;
                    hit  = !kill && (rdata_sel == key_reg);
                    skip = kill || (hit && drop_reg && !found_reg);
                    if (hit)
                    begin
                        found_next = 1'b1;
                    end
                    if (!skip)
                    begin
                        mem_we      = 1'b1;
                        wr_ptr_next = wr_ptr_reg + FILL_W'(1);
                    end
                end
                else if (rd_idx_reg >= scan_fill)
                begin
                    // scan done: kept entries are compacted below wr_ptr
                    if (append_reg && !found_reg && (wr_ptr_reg < FILL_W'(MAX_ENTRIES)))
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = key_reg;
                        new_fill  = wr_ptr_reg + FILL_W'(1);
                    end
                    if (state_reg == ST_PSCAN)
                    begin
                        pfill_next = new_fill;
                        if ((mode_reg == MODE_PROMOTE) && found_reg)
                        begin
                            rd_idx_next = '0;
                            wr_ptr_next = '0;
                            found_next  = 1'b0;
                            evict_next  = (cfill_reg >= eff_cap) && (cfill_reg != '0);
                            drop_next   = 1'b0;
                            append_next = 1'b1;
                            moved_next  = 1'b1;
                            state_next  = ST_CSCAN;
                        end
                        else
                        begin
                            state_next = ST_FINISH;
                        end
                    end
                    else
                    begin
                        cfill_next = new_fill;
                        state_next = ST_FINISH;
                    end
                end
            end

            ST_FINISH:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    out_valid_next = 1'b1;
                    out_pcnt_next  = COUNT_W'(pfill_reg);
                    out_ccnt_next  = COUNT_W'(cfill_reg);
                    out_total_next = TOTAL_W'(fill_sum);
                    out_moved_next = moved_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cap_reg       <= CAP_RESET;
            pfill_reg     <= '0;
            cfill_reg     <= '0;
            key_reg       <= '0;
            mode_reg      <= '0;
            rd_idx_reg    <= '0;
            wr_ptr_reg    <= '0;
            cmp_valid_reg <= 1'b0;
            cmp_first_reg <= 1'b0;
            found_reg     <= 1'b0;
            evict_reg     <= 1'b0;
            drop_reg      <= 1'b0;
            append_reg    <= 1'b0;
            moved_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            out_pcnt_reg  <= '0;
            out_ccnt_reg  <= '0;
            out_total_reg <= '0;
            out_moved_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cap_reg       <= cap_next;
            pfill_reg     <= pfill_next;
            cfill_reg     <= cfill_next;
            key_reg       <= key_next;
            mode_reg      <= mode_next;
            rd_idx_reg    <= rd_idx_next;
            wr_ptr_reg    <= wr_ptr_next;
            cmp_valid_reg <= cmp_valid_next;
            cmp_first_reg <= cmp_first_next;
            found_reg     <= found_next;
            evict_reg     <= evict_next;
            drop_reg      <= drop_next;
            append_reg    <= append_next;
            moved_reg     <= moved_next;
            out_valid_reg <= out_valid_next;
            out_pcnt_reg  <= out_pcnt_next;
            out_ccnt_reg  <= out_ccnt_next;
            out_total_reg <= out_total_next;
            out_moved_reg <= out_moved_next;
        end
    end

    assign cfg_ready       = 1'b1;
    assign item_stall      = (state_reg != ST_IDLE);
    assign result_valid    = out_valid_reg;
    assign pending_count   = out_pcnt_reg;
    assign confirmed_count = out_ccnt_reg;
    assign total_count     = out_total_reg;
    assign promoted        = out_moved_reg;

endmodule

`default_nettype wire
